// File: rtl/sorted_insert_list_core_assert.svh
// assertion helpers used by the core rtl
`ifndef SORTED_INSERT_LIST_CORE_ASSERT_SVH
`define SORTED_INSERT_LIST_CORE_ASSERT_SVH

// same-cycle implication
`define SIL_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sil_pkg.sv
package sil_pkg;

    localparam int SIL_CAPACITY = 16;

    typedef logic signed [31:0] t_value;

    typedef enum logic {
        REQ_INSERT  = 1'b0,
        REQ_READOUT = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_ELEMENT  = 2'd3
    } t_status;

    typedef struct packed {
        t_req   req_type;
        t_value value;
    } t_in_beat;

    typedef struct packed {
        t_status status;
        t_value  element;
        logic    last;
    } t_out_beat;

    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctrl;

endpackage

// File: rtl/sil_cell.sv
module sil_cell
    import sil_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  logic       i_occupied,
    input  logic       i_is_tail,
    input  logic       i_left_le,
    input  t_value     i_new_value,
    input  t_value     i_left_value,
    input  t_value     i_right_value,
    input  t_value     i_wrap_value,
    output t_value     o_value,
    output logic       o_le
);

    t_value r_value;
    t_value n_value;

    assign o_le    = i_occupied && (r_value <= i_new_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert) begin
            // keep if stored value stays ahead of the new one
            if (!o_le) begin
                n_value = i_left_le ? i_new_value : i_left_value;
            end
        end else if (i_ctrl.rotate) begin
            // tail of the occupied run takes the head value, wrapping around
            n_value = i_is_tail ? i_wrap_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

// File: rtl/sorted_insert_list_core.sv
// Sorted list of up to CAPACITY signed 32-bit values held in a row of cells, one value per
// cell, kept in ascending order. An insert beat is taken every cycle while no readout runs
// and the result register is free: every cell compares against the new value at once and
// the row shifts by one behind the insert point in the same cycle; it returns one status beat
// (inserted or full). A readout beat returns one element beat per stored value in ascending
// order, last marked, one element at a time as the row rotates one step toward cell 0 for
// each; the block then takes its next beat. A readout of an empty list returns a single empty
// beat. An output stall holds the readout and the input.
module sorted_insert_list_core
    import sil_pkg::*;
#(
    parameter int CAPACITY = SIL_CAPACITY
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

`include "sorted_insert_list_core_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic      r_out_valid, n_out_valid;
    t_out_beat r_out, n_out;

    t_cell_ctrl w_ctrl;
    t_value     w_value [CAPACITY];
    logic       w_le    [CAPACITY];

    logic w_out_free;
    logic w_in_acc;
    logic w_full;
    logic w_rd_last;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == S_READ) || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_rd_last  = ((CW'(r_rd_idx) + CW'(1)) == r_count);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_left_le;
        t_value w_left_value;
        t_value w_right_value;

        if (g == 0) begin : g_head
            assign w_left_le    = 1'b1;
            assign w_left_value = i_in_data.value;
        end else begin : g_body
            assign w_left_le    = w_le[g-1];
            assign w_left_value = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right_value = w_value[0];
        end else begin : g_mid
            assign w_right_value = w_value[g+1];
        end

        sil_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_occupied    (CW'(g) < r_count),
            .i_is_tail     (r_count == CW'(g + 1)),
            .i_left_le     (w_left_le),
            .i_new_value   (i_in_data.value),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .i_wrap_value  (w_value[0]),
            .o_value       (w_value[g]),
            .o_le          (w_le[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_ctrl      = '{insert: 1'b0, rotate: 1'b0};

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_out_valid = 1'b1;
                    n_out       = '{status: ST_INSERTED, element: '0, last: 1'b1};
                    if (i_in_data.req_type == REQ_INSERT) begin
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctrl.insert = 1'b1;
                            n_count       = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_out.status = ST_EMPTY;
                    end else begin
                        // elements follow from the read state
                        n_out_valid = 1'b0;
                        n_state     = S_READ;
                        n_rd_idx    = '0;
                    end
                end
            end
            S_READ: begin
                if (w_out_free) begin
                    w_ctrl.rotate = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out         = '{status: ST_ELEMENT, element: w_value[0],
                                      last: w_rd_last};
                    n_rd_idx      = r_rd_idx + IW'(1);
                    if (w_rd_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    `SIL_ASSERT_HOLDS(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY),
        "entry count above capacity")

    `SIL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n,
        w_in_acc && i_in_data.req_type == REQ_INSERT && !w_full,
        r_count == $past(r_count) + CW'(1), "insert did not grow the list")

    `SIL_ASSERT_NEXT(a_read_keeps_count, i_clk, i_rst_n, r_state == S_READ,
        $stable(r_count), "count changed during readout")

    `SIL_ASSERT_HOLDS(a_element_nonempty, i_clk, i_rst_n,
        r_out_valid && r_out.status == ST_ELEMENT, r_count != '0,
        "element beat from an empty list")

    `SIL_ASSERT_HOLDS(a_head_sorted, i_clk, i_rst_n,
        r_state == S_IDLE && r_count >= CW'(2), w_value[0] <= w_value[1],
        "head cells out of order")

endmodule

// File: test/sorted_insert_list_core_test.sv
module sorted_insert_list_core_test
    import sil_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 200;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    // predictor state: the list as the block should hold it
    t_value    sorted_values[$];
    t_out_beat pending_results[$];
    int        mismatch_count;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_requests;
    int holds_seen;
    int hold_left;

    sorted_insert_list_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic predict_list_results(input t_in_beat beat);
        t_out_beat r;
        int        pos;
        r.status  = ST_INSERTED;
        r.element = '0;
        r.last    = 1'b1;
        if (beat.req_type == REQ_INSERT) begin
            if (sorted_values.size() >= SIL_CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // new value goes after every stored value <= it
                pos = 0;
                foreach (sorted_values[i]) begin
                    if (sorted_values[i] <= beat.value) pos = i + 1;
                end
                sorted_values.insert(pos, beat.value);
            end
            pending_results.push_back(r);
        end else if (sorted_values.size() == 0) begin
            r.status = ST_EMPTY;
            pending_results.push_back(r);
        end else begin
            foreach (sorted_values[i]) begin
                r.status  = ST_ELEMENT;
                r.element = sorted_values[i];
                r.last    = (i == sorted_values.size() - 1);
                pending_results.push_back(r);
            end
        end
    endtask

    // receiver side: random stall, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: status %0d element %0d last %0d",
                       o_out_data.status, o_out_data.element, o_out_data.last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    mismatch_count++;
                end
                if (o_out_data.element !== want.element) begin
                    $error("element: expected %0d, got %0d",
                           want.element, o_out_data.element);
                    mismatch_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_data.last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_request(input t_req req, input t_value value);
        t_in_beat beat;
        beat.req_type = req;
        beat.value    = value;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_list_results(beat);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic t_value pick_value();
        case ($urandom_range(0, 5))
            0: pick_value = 32'sh7fff_ffff;
            1: pick_value = 32'sh8000_0000;
            2: pick_value = t_value'($urandom_range(0, 6)) - 3;
            default: pick_value = t_value'($urandom);
        endcase
    endfunction

    task automatic send_random_request();
        if ($urandom_range(0, 99) < 40) send_request(REQ_READOUT, t_value'($urandom));
        else send_request(REQ_INSERT, pick_value());
    endtask

    task automatic test_empty_readout();
        send_request(REQ_READOUT, 32'sh7fff_ffff);
        send_request(REQ_READOUT, 32'sh0);
    endtask

    // extremes and equal values, then read the partial list back
    task automatic test_extreme_inserts();
        send_request(REQ_INSERT, 32'sh7fff_ffff);
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_INSERT, 32'sh0);
        send_request(REQ_INSERT, -32'sd1);
        send_request(REQ_INSERT, 32'sd1);
        send_request(REQ_INSERT, 32'sh0);
        send_request(REQ_INSERT, 32'sh7fff_ffff);
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_READOUT, -32'sd1);
    endtask

    task automatic test_fill_to_capacity();
        while (sorted_values.size() < SIL_CAPACITY) send_request(REQ_INSERT, pick_value());
        send_request(REQ_INSERT, 32'sh8000_0000);
        send_request(REQ_INSERT, 32'sh7fff_ffff);
        send_request(REQ_READOUT, 32'sh0);
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct, input int count);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count) send_random_request();
    endtask

    // receiver holds off long enough that the block backs up into its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        repeat (12) send_random_request();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_idle_pct = 30;
        send_request(REQ_READOUT, 32'sh0);
        send_request(REQ_INSERT, pick_value());
        wait_for_drain();
        send_request(REQ_READOUT, t_value'($urandom));
        wait_for_drain();
        send_request(REQ_INSERT, 32'sh7fff_ffff);
        send_request(REQ_READOUT, 32'sh8000_0000);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        mismatch_count = 0;
        hold_requests  = 0;
        holds_seen     = 0;
        hold_left      = 0;
        send_idle_pct  = 21;
        recv_idle_pct  = 69;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_readout();
        test_extreme_inserts();
        test_fill_to_capacity();
        test_random_traffic(21, 69, 65);
        test_random_traffic(69, 21, 65);
        test_random_traffic(0, 0, 65);
        test_backpressure();
        test_drain_pause();

        wait_for_drain();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
